[hdl/adwm_pkg.sv]
// Shared types and constants of the audio distortion block.
`default_nettype none

package adwm_pkg;

  // Shaping modes held in the mode register.
  typedef enum logic [1:0] {
    ModeSoft   = 2'd0,
    ModeHard   = 2'd1,
    ModeCrush  = 2'd2,
    ModeBypass = 2'd3
  } shape_mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegShapeMode = 2'd0,
    RegDriveGain = 2'd1,
    RegWetMix    = 2'd2
  } cfg_index_e;

  // Mix value for a fully wet output, Q1.15.
  localparam logic [15:0] MixOne = 16'h8000;

  // Hard clip threshold, 0.55 in Q1.15.
  localparam logic [19:0] HardThresh = 20'd18022;

  // ceil(2^33 / 3): exact division by three of any 32-bit value.
  localparam logic [31:0] DivThreeRecip = 32'hAAAA_AAAB;

  // Register stages from input to output register.
  localparam int unsigned PipeDepth = 10;

  // Settings as seen by the datapath.
  typedef struct packed {
    shape_mode_e mode;
    logic [15:0] drive;  // unsigned Q4.12
    logic [15:0] mix;    // wet weight, limited to 1.0
    logic [15:0] dry;    // dry weight, 1.0 - mix
  } cfg_t;

endpackage

`default_nettype wire

[hdl/adwm_cfg.sv]
// Configuration registers with mix limiting and dry weight.
`default_nettype none

module adwm_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [1:0]    wr_index_i,
  input  wire logic [15:0]   wr_data_i,
  output adwm_pkg::cfg_t     cfg_o
);
  import adwm_pkg::*;

  shape_mode_e mode_q;
  logic [15:0] drive_q;
  logic [15:0] mix_q;
  logic [15:0] mix_lim;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBypass;
      drive_q <= 16'd4096;
      mix_q   <= MixOne;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        RegShapeMode: mode_q  <= shape_mode_e'(wr_data_i[1:0]);
        RegDriveGain: drive_q <= wr_data_i;
        RegWetMix:    mix_q   <= wr_data_i;
        default: ;
      endcase
    end
  end

  // A mix above one counts as fully wet.
  assign mix_lim = (mix_q > MixOne) ? MixOne : mix_q;

  assign cfg_o.mode  = mode_q;
  assign cfg_o.drive = drive_q;
  assign cfg_o.mix   = mix_lim;
  assign cfg_o.dry   = MixOne - mix_lim;

endmodule

`default_nettype wire

[hdl/audio_distortion_with_mix.sv]
// A request is captured in stage 0 and passes stages 1 to 8 into the output register.
// Throughput: one sample per cycle while the output is not stalled; each stage holds its sample
// only while the next stage is full and stalled, so bubbles close up during an output stall.
// The soft clip cube sets the depth: square, split cube and divide by three each get
// a stage. Reset clears all stage valid bits and loads bypass, unity drive, full mix.
`default_nettype none

module audio_distortion_with_mix #(
  parameter int unsigned CRUSH_BITS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] in_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      out_sample_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  import adwm_pkg::*;

  // Crusher levels and the reciprocal used to divide by them.
  localparam int unsigned CrushM  = (1 << CRUSH_BITS) - 1;
  localparam int unsigned CrushNW = CRUSH_BITS + 16;
  localparam int unsigned CrushS  = 2 * CRUSH_BITS + 16;
  localparam int unsigned RecipW  = CRUSH_BITS + 18;
  localparam int unsigned ProdW   = CrushNW + RecipW;
  localparam logic [63:0] CrushRecip =
    ((64'd1 << CrushS) + 64'(CrushM) - 64'd1) / 64'(CrushM);
  localparam logic [CRUSH_BITS-1:0] CrushMVal   = CRUSH_BITS'(CrushM);
  localparam logic [14:0]           CrushHalf   = 15'(CrushM >> 1);
  localparam logic [RecipW-1:0]     CrushRecipV = RecipW'(CrushRecip);
  localparam logic [57:0]           CubeBias    = 58'd3 << 29;

  cfg_t cfg_s;

  logic [PipeDepth-1:0] vld_q;
  logic [PipeDepth-1:0] vld_d;
  logic [PipeDepth-1:0] adv;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  adwm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg_s)
  );

  // Stage advance: a stage loads when it is empty or its successor loads.
  always_comb begin
    adv[PipeDepth-1] = !vld_q[PipeDepth-1] || !out_stall_i;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < PipeDepth; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[PipeDepth-1];

  // Stage 0 inputs: drive gain on |x| and crusher level scaling.
  logic [16:0]         absx_c;
  logic [32:0]         gprod_c;
  logic [CrushNW-1:0]  cprod_c;

  assign absx_c  = in_sample_i[15] ? (17'd0 - {1'b1, in_sample_i}) : {1'b0, in_sample_i};
  assign gprod_c = {17'd0, cfg_s.drive} * {16'd0, absx_c};
  assign cprod_c = {{CRUSH_BITS{1'b0}}, ~in_sample_i[15], in_sample_i[14:0]} *
                   {16'd0, CrushMVal};

  logic signed [15:0]  s0_x_q;
  logic [31:0]         s0_gmag_q;
  logic [CrushNW-1:0]  s0_cp_q;

  // Stage 1 inputs: round the gained sample and the crusher level.
  logic [31:0]         gsum_c;
  logic [CrushNW-1:0]  ksum_c;

  assign gsum_c = s0_gmag_q + 32'd2048;
  assign ksum_c = s0_cp_q + CrushNW'(16384);

  logic signed [15:0]  s1_x_q;
  logic [19:0]         s1_a_q;
  logic [CrushNW-1:0]  s1_n_q;

  // Stage 2 inputs: square of the gained magnitude, crusher quotient.
  logic [39:0]         sq_c;
  logic [ProdW-1:0]    cquo_c;

  assign sq_c   = {20'd0, s1_a_q} * {20'd0, s1_a_q};
  assign cquo_c = {{RecipW{1'b0}}, s1_n_q} * {{CrushNW{1'b0}}, CrushRecipV};

  logic signed [15:0]  s2_x_q;
  logic [19:0]         s2_a_q;
  logic [37:0]         s2_sq_q;
  logic [16:0]         s2_cq_q;

  // Stage 3 inputs: cube in two partial products.
  logic [38:0]         plo_c;
  logic [38:0]         phi_c;

  assign plo_c = {19'd0, s2_a_q} * {20'd0, s2_sq_q[18:0]};
  assign phi_c = {19'd0, s2_a_q} * {20'd0, s2_sq_q[37:19]};

  logic signed [15:0]  s3_x_q;
  logic [19:0]         s3_a_q;
  logic [16:0]         s3_cq_q;
  logic [38:0]         s3_plo_q;
  logic [38:0]         s3_phi_q;

  // Stage 4 inputs: cube plus half of 3 * 2^30, then the power of two part.
  logic [57:0]         cube_c;

  assign cube_c = {s3_phi_q, 19'd0} + {19'd0, s3_plo_q} + CubeBias;

  logic signed [15:0]  s4_x_q;
  logic [19:0]         s4_a_q;
  logic [16:0]         s4_cq_q;
  logic [27:0]         s4_q1_q;

  // Stage 5 inputs: divide by three.
  logic [59:0]         d3_c;

  assign d3_c = {32'd0, s4_q1_q} * {28'd0, DivThreeRecip};

  logic signed [15:0]  s5_x_q;
  logic [19:0]         s5_a_q;
  logic [16:0]         s5_cq_q;
  logic [26:0]         s5_q_q;

  // Stage 6 inputs: wet sample for the selected mode, clip signs restored from x.
  logic                neg5;
  logic signed [27:0]  sdiff_c;
  logic signed [27:0]  soft_c;
  logic [19:0]         hmag_c;
  logic signed [26:0]  hard_c;
  logic signed [26:0]  crush_c;
  logic signed [26:0]  wet_c;

  assign neg5    = s5_x_q[15];
  assign sdiff_c = $signed({8'd0, s5_a_q}) - $signed({1'b0, s5_q_q});
  assign soft_c  = neg5 ? -sdiff_c : sdiff_c;
  assign hmag_c  = (s5_a_q > HardThresh) ? HardThresh : s5_a_q;
  assign hard_c  = neg5 ? -$signed({7'd0, hmag_c}) : $signed({7'd0, hmag_c});
  assign crush_c = $signed({10'd0, s5_cq_q}) - 27'sd32768;

  always_comb begin
    case (cfg_s.mode)
      ModeSoft:  wet_c = soft_c[26:0];
      ModeHard:  wet_c = hard_c;
      ModeCrush: wet_c = crush_c;
      default:   wet_c = {{11{s5_x_q[15]}}, s5_x_q};
    endcase
  end

  logic signed [15:0]  s6_x_q;
  logic signed [26:0]  s6_wet_q;

  // Stage 7 inputs: dry and wet weighting.
  logic signed [32:0]  dryp_c;
  logic signed [43:0]  wetp_c;

  assign dryp_c = s6_x_q * $signed({1'b0, cfg_s.dry});
  assign wetp_c = s6_wet_q * $signed({1'b0, cfg_s.mix});

  logic signed [32:0]  s7_dry_q;
  logic signed [43:0]  s7_wet_q;

  logic signed [43:0]  s8_sum_q;

  // Output stage: round by 2^15 away from zero, then saturate.
  logic                negs;
  logic [43:0]         smag_c;
  logic [43:0]         srnd_c;
  logic [28:0]         rmag_c;
  logic signed [15:0]  y_c;

  assign negs   = s8_sum_q[43];
  assign smag_c = negs ? (44'd0 - s8_sum_q) : s8_sum_q;
  assign srnd_c = smag_c + 44'd16384;
  assign rmag_c = srnd_c[43:15];

  always_comb begin
    if (negs) begin
      y_c = (rmag_c > 29'd32768) ? 16'sh8000 : $signed(16'd0 - rmag_c[15:0]);
    end else begin
      y_c = (rmag_c > 29'd32767) ? 16'sh7FFF : $signed(rmag_c[15:0]);
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_x_q    <= in_sample_i;
      s0_gmag_q <= gprod_c[31:0];
      s0_cp_q   <= cprod_c;
    end
    if (adv[1]) begin
      s1_x_q <= s0_x_q;
      s1_a_q <= gsum_c[31:12];
      s1_n_q <= {ksum_c[CrushNW-1:15], CrushHalf};
    end
    if (adv[2]) begin
      s2_x_q  <= s1_x_q;
      s2_a_q  <= s1_a_q;
      s2_sq_q <= sq_c[37:0];
      s2_cq_q <= cquo_c[CrushS +: 17];
    end
    if (adv[3]) begin
      s3_x_q   <= s2_x_q;
      s3_a_q   <= s2_a_q;
      s3_cq_q  <= s2_cq_q;
      s3_plo_q <= plo_c;
      s3_phi_q <= phi_c;
    end
    if (adv[4]) begin
      s4_x_q  <= s3_x_q;
      s4_a_q  <= s3_a_q;
      s4_cq_q <= s3_cq_q;
      s4_q1_q <= cube_c[57:30];
    end
    if (adv[5]) begin
      s5_x_q  <= s4_x_q;
      s5_a_q  <= s4_a_q;
      s5_cq_q <= s4_cq_q;
      s5_q_q  <= d3_c[59:33];
    end
    if (adv[6]) begin
      s6_x_q   <= s5_x_q;
      s6_wet_q <= wet_c;
    end
    if (adv[7]) begin
      s7_dry_q <= dryp_c;
      s7_wet_q <= wetp_c;
    end
    if (adv[8]) begin
      s8_sum_q <= s7_wet_q + 44'(s7_dry_q);
    end
    if (adv[9]) begin
      out_sample_o <= y_c;
    end
  end

endmodule

`default_nettype wire

[hdl/adwm_checker.sv]
// Port-level checks of the audio distortion block, bound to its top level.
`default_nettype none

module adwm_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [15:0] out_sample_i
);
  import adwm_pkg::*;

  localparam int unsigned CntW = $clog2(PipeDepth + 1);

  logic            in_take;
  logic            out_take;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  // Samples inside the block: accepted requests not yet delivered.
  assign in_take  = in_valid_i && !in_stall_i;
  assign out_take = out_valid_i && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_take && !out_take) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_take && out_take) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_sample_i))
    else $error("stalled result changed");

  // Input stalls only when the output is backed up.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled without output stall");

  // A result needs a sample in flight.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without accepted sample");

  // A full pipeline under stall refuses new samples.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(PipeDepth)) && out_stall_i |-> in_stall_i)
    else $error("sample accepted into a full pipeline");

endmodule

bind audio_distortion_with_mix adwm_checker u_adwm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_i (out_sample_o)
);

`default_nettype wire
